// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/sitdc_pkg.sv -----
// package: types and constants for the integer to decimal text converter
package sitdc_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 6;
  localparam int DIGIT_W    = 4;
  localparam int MAX_DIGITS = 10;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int PROD_W     = 2 * VALUE_W;
  localparam int Q_SHIFT    = 35;

  localparam logic [CHAR_W-1:0]  CODE_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0]  CODE_ZERO  = 6'd48;
  localparam logic [VALUE_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic div;
    logic pop;
    logic minus;
  } cmd_t;

  typedef struct packed {
    logic q_zero;
    logic negative;
    logic one_left;
  } stat_t;

endpackage

// ----- sv/signed_int_to_decimal_chars.sv -----
// top level: signed 32-bit integer to decimal ascii characters
//
//  channel  | handshake         | payload
//  ---------+-------------------+-------------------
//  request  | start / busy      | value
//  result   | strobe            | char_code, last
//
// a request is taken in an idle cycle, then the divide-by-ten unit runs once
// per decimal digit (one reciprocal multiply per digit)
// then the sign (if negative) and the digits leave one per cycle, msb first
// rst clears the state machine only; results cannot be stalled
module signed_int_to_decimal_chars
  import sitdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value,
  output logic               strobe,
  output logic [CHAR_W-1:0]  char_code,
  output logic               last
);

  cmd_t  cmd;
  stat_t stat;

  sitdc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe),
    .last   (last)
  );

  sitdc_datapath u_dp (
    .clk       (clk),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .char_code (char_code)
  );

endmodule

// ----- sv/sitdc_datapath.sv -----
// datapath: magnitude register, divide-by-ten step and digit stack
module sitdc_datapath
  import sitdc_pkg::*;
(
  input  logic                clk,
  input  logic [VALUE_W-1:0]  value,
  input  cmd_t                cmd,
  output stat_t               stat,
  output logic [CHAR_W-1:0]   char_code
);

  logic [VALUE_W-1:0] mag;
  logic               negative;
  logic [DIGIT_W-1:0] digits [MAX_DIGITS];
  logic [CNT_W-1:0]   cnt;

  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] rem_full;
  logic [DIGIT_W-1:0] rem;

  // quotient by reciprocal multiply, exact for all 32-bit values
  assign prod     = PROD_W'(mag) * PROD_W'(RECIP_TEN);
  assign quot     = VALUE_W'(prod >> Q_SHIFT);
  assign rem_full = mag - ((quot << 3) + (quot << 1));
  assign rem      = rem_full[DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      negative <= value[VALUE_W-1];
      mag      <= value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
      cnt      <= '0;
    end else if (cmd.div) begin
      mag       <= quot;
      cnt       <= cnt + CNT_W'(1);
      digits[0] <= rem;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        digits[i] <= digits[i-1];
      end
    end else if (cmd.pop) begin
      cnt <= cnt - CNT_W'(1);
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        digits[i] <= digits[i+1];
      end
    end
  end

  assign stat.q_zero   = (quot == '0);
  assign stat.negative = negative;
  assign stat.one_left = (cnt == CNT_W'(1));

  assign char_code = cmd.minus ? CODE_MINUS : (CODE_ZERO + CHAR_W'(digits[0]));

endmodule

// ----- sv/sitdc_ctrl.sv -----
// controller: state machine sequencing division and character output
module sitdc_ctrl
  import sitdc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  strobe,
  output logic  last
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    strobe     = 1'b0;
    last       = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (stat.q_zero) begin
          state_next = stat.negative ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        cmd.minus  = 1'b1;
        strobe     = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.pop = 1'b1;
        strobe  = 1'b1;
        last    = stat.one_left;
        if (stat.one_left) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/sitdc_checker.sv -----
// checker: port-level assertions for the converter, bound to the top level
`include "assert_macros.svh"

module sitdc_checker
  import sitdc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              strobe,
  input logic [CHAR_W-1:0] char_code,
  input logic              last
);

  logic code_ok;

  assign code_ok = (char_code == CODE_MINUS) ||
                   (char_code >= CODE_ZERO && char_code <= CODE_ZERO + 6'd9);

  `ASSERT_NOW(a_strobe_busy, clk, rst, strobe, busy)
  `ASSERT_NEXT(a_last_frees, clk, rst, strobe && last, !busy)
  `ASSERT_NOW(a_minus_not_last, clk, rst, strobe && char_code == CODE_MINUS, !last)
  `ASSERT_NOW(a_code_legal, clk, rst, strobe, code_ok)
  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy && !strobe)

endmodule

bind signed_int_to_decimal_chars sitdc_checker u_sitdc_checker (.*);
